// File: rtl/assert_macros.svh
// Assertion macros shared by the projected joint bounding box RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define PJBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pjbb: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define PJBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pjbb: assertion failed");

`endif

// File: rtl/pjbb_pkg.sv
// Types, constants and arithmetic helpers of the projected joint bounding box.
`default_nettype none

package pjbb_pkg;

  // Fixed-point format and image geometry.
  localparam int FRAC_BITS   = 24;
  localparam int BLOCK_EDGE  = 8;            // a power of two
  localparam int BLOCK_SHIFT = $clog2(BLOCK_EDGE);
  localparam int IMAGE_COLS  = 320;

  // Field widths.
  localparam int POS_W      = 15;
  localparam int PIX_W      = 12;
  localparam int BLK_W      = 9;
  localparam int MODE_W     = 2;
  localparam int OFS_W      = 40;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Datapath widths: one product, and the sum of an offset and three products.
  localparam int PROD_W = GAIN_W + POS_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int QUO_W  = ACC_W - FRAC_BITS;

  // Queue between the front and the back, and the result queue.
  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = MID_AW + 1;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = OUT_AW + 1;

  // Saturation limits.
  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
  localparam logic signed [BLK_W-1:0] BLK_MAX = {1'b0, {(BLK_W-1){1'b1}}};
  localparam logic signed [BLK_W-1:0] BLK_MIN = {1'b1, {(BLK_W-1){1'b0}}};

  // Register reset values.
  localparam logic signed [OFS_W-1:0]  COL_OFFSET_RST = 40'sd2631648040;
  localparam logic signed [GAIN_W-1:0] COL_GAIN_X_RST = 32'sd1638902;
  localparam logic signed [GAIN_W-1:0] COL_GAIN_Y_RST = -32'sd10812;
  localparam logic signed [GAIN_W-1:0] COL_GAIN_Z_RST = 32'sd26367;
  localparam logic signed [OFS_W-1:0]  ROW_OFFSET_RST = 40'sd2106139895;
  localparam logic signed [GAIN_W-1:0] ROW_GAIN_X_RST = 32'sd3613;
  localparam logic signed [GAIN_W-1:0] ROW_GAIN_Y_RST = -32'sd1987889;
  localparam logic signed [GAIN_W-1:0] ROW_GAIN_Z_RST = -32'sd37136;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_OFFSET = 3'd0,
    REG_COL_GAIN_X = 3'd1,
    REG_COL_GAIN_Y = 3'd2,
    REG_COL_GAIN_Z = 3'd3,
    REG_ROW_OFFSET = 3'd4,
    REG_ROW_GAIN_X = 3'd5,
    REG_ROW_GAIN_Y = 3'd6,
    REG_ROW_GAIN_Z = 3'd7
  } reg_idx_t;

  // Box shapes.
  typedef enum logic [MODE_W-1:0] {
    MODE_BOX   = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } box_mode_t;

  // One projected point as it travels from the front to the back.
  typedef struct packed {
    logic signed [PIX_W-1:0] col;
    logic signed [PIX_W-1:0] row;
    logic [MODE_W-1:0]       mode;
    logic                    last;
  } point_t;

  // Status of the queue between front and back.
  typedef struct packed {
    logic              empty;
    logic [MID_CW-1:0] count;
  } mid_stat_t;

  // One finished box.
  typedef struct packed {
    logic signed [PIX_W-1:0] min_col;
    logic signed [PIX_W-1:0] min_row;
    logic signed [PIX_W-1:0] max_col;
    logic signed [PIX_W-1:0] max_row;
    logic signed [BLK_W-1:0] min_block_col;
    logic signed [BLK_W-1:0] min_block_row;
    logic signed [BLK_W-1:0] max_block_col;
    logic signed [BLK_W-1:0] max_block_row;
  } result_t;

  // Full-precision product of a gain and a position.
  function automatic logic signed [PROD_W-1:0] mul_gain(
    input logic signed [GAIN_W-1:0] gain,
    input logic signed [POS_W-1:0]  pos
  );
    logic signed [PROD_W-1:0] g;
    logic signed [PROD_W-1:0] p;
    begin
      g = PROD_W'(gain);
      p = PROD_W'(pos);
      return g * p;
    end
  endfunction

  // Drop the fraction toward zero and saturate to the pixel range.
  function automatic logic signed [PIX_W-1:0] pix_of_acc(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [QUO_W-1:0] q;
    logic                    round_up;
    begin
      q        = QUO_W'(acc >>> FRAC_BITS);
      round_up = acc[ACC_W-1] && (acc[FRAC_BITS-1:0] != '0);
      q        = q + $signed({{(QUO_W-1){1'b0}}, round_up});
      if (q < PIX_MIN) begin
        return PIX_MIN;
      end else if (q > PIX_MAX) begin
        return PIX_MAX;
      end
      return PIX_W'(q);
    end
  endfunction

  // Pixel divided by the block edge, toward zero, saturated to the block range.
  function automatic logic signed [BLK_W-1:0] block_of(
    input logic signed [PIX_W-1:0] c
  );
    logic signed [PIX_W:0] ext;
    logic        [PIX_W:0] bias;
    logic signed [PIX_W:0] b;
    begin
      ext  = (PIX_W+1)'(c);
      bias = c[PIX_W-1] ? (PIX_W+1)'(BLOCK_EDGE - 1) : '0;
      b    = (ext + $signed(bias)) >>> BLOCK_SHIFT;
      if (b < BLK_MIN) begin
        return BLK_MIN;
      end else if (b > BLK_MAX) begin
        return BLK_MAX;
      end
      return BLK_W'(b);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/pjbb_mid_queue.sv
// Queue of projected points between the projection front and the box back.
`default_nettype none

module pjbb_mid_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr_en,
  input  pjbb_pkg::point_t     wr_data,
  input  wire                  rd_en,
  output pjbb_pkg::point_t     rd_data,
  output pjbb_pkg::mid_stat_t  stat
);

  pjbb_pkg::point_t                   mem [pjbb_pkg::MID_DEPTH];
  logic [pjbb_pkg::MID_AW-1:0]        wr_ptr;
  logic [pjbb_pkg::MID_AW-1:0]        rd_ptr;
  logic [pjbb_pkg::MID_CW-1:0]        count;

  // Storage; the writer never pushes more than the queue holds.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data    = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

`default_nettype wire

// File: rtl/pjbb_front.sv
// Front: configuration registers and the three-stage projection pipeline.
`default_nettype none
`include "assert_macros.svh"

module pjbb_front (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [pjbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [pjbb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                  push,
  output logic                                 full,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_x,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_y,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_z,
  input  wire  [pjbb_pkg::MODE_W-1:0]          box_mode,
  input  wire                                  last_point,
  input  pjbb_pkg::mid_stat_t                  mid_stat,
  output logic                                 mid_wr,
  output pjbb_pkg::point_t                     mid_data
);

  logic signed [pjbb_pkg::OFS_W-1:0]  col_offset;
  logic signed [pjbb_pkg::GAIN_W-1:0] col_gain_x;
  logic signed [pjbb_pkg::GAIN_W-1:0] col_gain_y;
  logic signed [pjbb_pkg::GAIN_W-1:0] col_gain_z;
  logic signed [pjbb_pkg::OFS_W-1:0]  row_offset;
  logic signed [pjbb_pkg::GAIN_W-1:0] row_gain_x;
  logic signed [pjbb_pkg::GAIN_W-1:0] row_gain_y;
  logic signed [pjbb_pkg::GAIN_W-1:0] row_gain_z;

  logic                               accept;
  logic [pjbb_pkg::MID_CW:0]          occupancy;

  // Stage one: products.
  logic                               v1;
  logic signed [pjbb_pkg::PROD_W-1:0] col_px, col_py, col_pz;
  logic signed [pjbb_pkg::PROD_W-1:0] row_px, row_py, row_pz;
  logic [pjbb_pkg::MODE_W-1:0]        mode1;
  logic                               last1;

  // Stage two: sums.
  logic                               v2;
  logic signed [pjbb_pkg::ACC_W-1:0]  col_acc, row_acc;
  logic [pjbb_pkg::MODE_W-1:0]        mode2;
  logic                               last2;

  // Stage three: pixels.
  logic                               v3;
  logic signed [pjbb_pkg::PIX_W-1:0]  col_pix, row_pix;
  logic [pjbb_pkg::MODE_W-1:0]        mode3;
  logic                               last3;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_offset <= pjbb_pkg::COL_OFFSET_RST;
      col_gain_x <= pjbb_pkg::COL_GAIN_X_RST;
      col_gain_y <= pjbb_pkg::COL_GAIN_Y_RST;
      col_gain_z <= pjbb_pkg::COL_GAIN_Z_RST;
      row_offset <= pjbb_pkg::ROW_OFFSET_RST;
      row_gain_x <= pjbb_pkg::ROW_GAIN_X_RST;
      row_gain_y <= pjbb_pkg::ROW_GAIN_Y_RST;
      row_gain_z <= pjbb_pkg::ROW_GAIN_Z_RST;
    end else if (cfg_valid) begin
      unique case (pjbb_pkg::reg_idx_t'(cfg_index))
        pjbb_pkg::REG_COL_OFFSET: col_offset <= cfg_data;
        pjbb_pkg::REG_COL_GAIN_X: col_gain_x <= cfg_data[pjbb_pkg::GAIN_W-1:0];
        pjbb_pkg::REG_COL_GAIN_Y: col_gain_y <= cfg_data[pjbb_pkg::GAIN_W-1:0];
        pjbb_pkg::REG_COL_GAIN_Z: col_gain_z <= cfg_data[pjbb_pkg::GAIN_W-1:0];
        pjbb_pkg::REG_ROW_OFFSET: row_offset <= cfg_data;
        pjbb_pkg::REG_ROW_GAIN_X: row_gain_x <= cfg_data[pjbb_pkg::GAIN_W-1:0];
        pjbb_pkg::REG_ROW_GAIN_Y: row_gain_y <= cfg_data[pjbb_pkg::GAIN_W-1:0];
        pjbb_pkg::REG_ROW_GAIN_Z: row_gain_z <= cfg_data[pjbb_pkg::GAIN_W-1:0];
      endcase
    end
  end

  // Credit check: the pipeline never stalls, so every point in flight
  // must already own a slot in the queue.
  assign occupancy = (pjbb_pkg::MID_CW+1)'(mid_stat.count)
                   + (pjbb_pkg::MID_CW+1)'(v1)
                   + (pjbb_pkg::MID_CW+1)'(v2)
                   + (pjbb_pkg::MID_CW+1)'(v3);
  assign full   = (occupancy >= (pjbb_pkg::MID_CW+1)'(pjbb_pkg::MID_DEPTH));
  assign accept = push && !full;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Six independent multiplies.
  always_ff @(posedge clk) begin
    col_px <= pjbb_pkg::mul_gain(col_gain_x, pos_x);
    col_py <= pjbb_pkg::mul_gain(col_gain_y, pos_y);
    col_pz <= pjbb_pkg::mul_gain(col_gain_z, pos_z);
    row_px <= pjbb_pkg::mul_gain(row_gain_x, pos_x);
    row_py <= pjbb_pkg::mul_gain(row_gain_y, pos_y);
    row_pz <= pjbb_pkg::mul_gain(row_gain_z, pos_z);
    mode1  <= box_mode;
    last1  <= last_point;
  end

  // Offset plus the three products, exact.
  always_ff @(posedge clk) begin
    col_acc <= pjbb_pkg::ACC_W'(col_offset) + pjbb_pkg::ACC_W'(col_px)
             + pjbb_pkg::ACC_W'(col_py) + pjbb_pkg::ACC_W'(col_pz);
    row_acc <= pjbb_pkg::ACC_W'(row_offset) + pjbb_pkg::ACC_W'(row_px)
             + pjbb_pkg::ACC_W'(row_py) + pjbb_pkg::ACC_W'(row_pz);
    mode2   <= mode1;
    last2   <= last1;
  end

  // Integer pixel, truncated toward zero and saturated.
  always_ff @(posedge clk) begin
    col_pix <= pjbb_pkg::pix_of_acc(col_acc);
    row_pix <= pjbb_pkg::pix_of_acc(row_acc);
    mode3   <= mode2;
    last3   <= last2;
  end

  assign mid_wr        = v3;
  assign mid_data.col  = col_pix;
  assign mid_data.row  = row_pix;
  assign mid_data.mode = mode3;
  assign mid_data.last = last3;

  // Points in flight plus queued points never exceed the queue depth.
  `PJBB_ASSERT_IMP(a_front_credit, 1'b1,
    occupancy <= (pjbb_pkg::MID_CW+1)'(pjbb_pkg::MID_DEPTH))

endmodule

`default_nettype wire

// File: rtl/pjbb_back.sv
// Back: running min and max, box shaping and the result queue.
`default_nettype none
`include "assert_macros.svh"

module pjbb_back (
  input  wire                  clk,
  input  wire                  rst,
  input  pjbb_pkg::mid_stat_t  mid_stat,
  input  pjbb_pkg::point_t     mid_data,
  output logic                 mid_rd,
  input  wire                  pop,
  output logic                 empty,
  output pjbb_pkg::result_t    res
);

  localparam logic signed [pjbb_pkg::PIX_W:0] EDGE_X =
    (pjbb_pkg::PIX_W+1)'(pjbb_pkg::BLOCK_EDGE);
  localparam logic signed [pjbb_pkg::PIX_W:0] COLS_X =
    (pjbb_pkg::PIX_W+1)'(pjbb_pkg::IMAGE_COLS);

  logic signed [pjbb_pkg::PIX_W-1:0] run_min_col, run_max_col;
  logic signed [pjbb_pkg::PIX_W-1:0] run_min_row, run_max_row;
  logic signed [pjbb_pkg::PIX_W-1:0] col_lo, col_hi, row_lo, row_hi;

  // Finished run waiting for shaping.
  logic                              b_valid;
  logic signed [pjbb_pkg::PIX_W-1:0] b_min_col, b_max_col, b_min_row, b_max_row;
  logic [pjbb_pkg::MODE_W-1:0]       b_mode;

  logic signed [pjbb_pkg::PIX_W-1:0] c0, r0, c1, r1;
  logic signed [pjbb_pkg::PIX_W:0]   left_end, right_start;
  pjbb_pkg::result_t                 shaped;

  // Result queue.
  pjbb_pkg::result_t                 out_mem [pjbb_pkg::OUT_DEPTH];
  logic [pjbb_pkg::OUT_AW-1:0]       out_wr_ptr, out_rd_ptr;
  logic [pjbb_pkg::OUT_CW-1:0]       out_count;
  logic                              out_pop;
  logic                              take;

  // Take a point when both the shaping slot and the result queue have room.
  assign take   = !mid_stat.empty
                && ((out_count + pjbb_pkg::OUT_CW'(b_valid))
                    < pjbb_pkg::OUT_CW'(pjbb_pkg::OUT_DEPTH));
  assign mid_rd = take;

  // Running extremes including the point being taken.
  always_comb begin
    col_lo = (mid_data.col < run_min_col) ? mid_data.col : run_min_col;
    col_hi = (mid_data.col > run_max_col) ? mid_data.col : run_max_col;
    row_lo = (mid_data.row < run_min_row) ? mid_data.row : run_min_row;
    row_hi = (mid_data.row > run_max_row) ? mid_data.row : run_max_row;
  end

  // Run state restarts after the last point of a run.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_col <= pjbb_pkg::PIX_MAX;
      run_min_row <= pjbb_pkg::PIX_MAX;
      run_max_col <= '0;
      run_max_row <= '0;
      b_valid     <= 1'b0;
    end else begin
      b_valid <= take && mid_data.last;
      if (take) begin
        if (mid_data.last) begin
          run_min_col <= pjbb_pkg::PIX_MAX;
          run_min_row <= pjbb_pkg::PIX_MAX;
          run_max_col <= '0;
          run_max_row <= '0;
        end else begin
          run_min_col <= col_lo;
          run_min_row <= row_lo;
          run_max_col <= col_hi;
          run_max_row <= row_hi;
        end
      end
    end
  end

  // Corners of the finished run.
  always_ff @(posedge clk) begin
    if (take && mid_data.last) begin
      b_min_col <= col_lo;
      b_max_col <= col_hi;
      b_min_row <= row_lo;
      b_max_row <= row_hi;
      b_mode    <= mid_data.mode;
    end
  end

  // Hand strips: one block wide, clamped to the image columns.
  always_comb begin
    left_end    = (pjbb_pkg::PIX_W+1)'(b_min_col) + EDGE_X;
    right_start = (pjbb_pkg::PIX_W+1)'(b_max_col) - EDGE_X;
    c0 = b_min_col;
    r0 = b_min_row;
    c1 = b_max_col;
    r1 = b_max_row;
    unique case (b_mode)
      pjbb_pkg::MODE_LEFT: begin
        c1 = (left_end > COLS_X) ? pjbb_pkg::PIX_W'(COLS_X)
                                 : left_end[pjbb_pkg::PIX_W-1:0];
        r1 = b_min_row;
      end
      pjbb_pkg::MODE_RIGHT: begin
        c0 = (right_start < 0) ? '0 : right_start[pjbb_pkg::PIX_W-1:0];
        r0 = b_max_row;
      end
      pjbb_pkg::MODE_BOX: begin
        c0 = b_min_col;
      end
      default: begin
        c0 = b_min_col;
      end
    endcase
  end

  always_comb begin
    shaped.min_col       = c0;
    shaped.min_row       = r0;
    shaped.max_col       = c1;
    shaped.max_row       = r1;
    shaped.min_block_col = pjbb_pkg::block_of(c0);
    shaped.min_block_row = pjbb_pkg::block_of(r0);
    shaped.max_block_col = pjbb_pkg::block_of(c1);
    shaped.max_block_row = pjbb_pkg::block_of(r1);
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (b_valid) begin
      out_mem[out_wr_ptr] <= shaped;
    end
  end

  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (b_valid) begin
        out_wr_ptr <= out_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + 1'b1;
      end
      if (b_valid && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (!b_valid && out_pop) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  assign empty = (out_count == '0);
  assign res   = out_mem[out_rd_ptr];

  // A finished box always finds room in the result queue.
  `PJBB_ASSERT_IMP(a_out_room, b_valid,
    out_count < pjbb_pkg::OUT_CW'(pjbb_pkg::OUT_DEPTH))
  // Taking the last point of a run returns the run state to its start.
  `PJBB_ASSERT_NXT(a_run_restart, take && mid_data.last,
    run_min_col == pjbb_pkg::PIX_MAX && run_min_row == pjbb_pkg::PIX_MAX
    && run_max_col == '0 && run_max_row == '0)

endmodule

`default_nettype wire

// File: rtl/projected_joint_bounding_box.sv
// Top level of the projected joint bounding box: front, point queue and back.
//
// Usage: joint points enter through a queue-style port (push/full); each is
// projected to a pixel column and row with the configured affine map.
// The last point of a run closes the run and yields one box with its block
// indices, read through a queue-style port (empty/pop). Other points give
// no result. Registers are written over cfg_valid/cfg_ready, which is always
// ready; write them only while no run is in progress.
// A result becomes visible after the last point of its run has passed the
// three projection stages, the point queue, and the box shaping stage.
// Throughput: one point per cycle while full is low; the multiplier stage
// and the min/max update each handle one point per cycle unless stalled.
// Reset (synchronous, rst high) restores the register reset values, empties
// both queues and restarts the run.
// When the receiver stops popping, the four-entry result queue fills, the
// back stops taking points, the eight-entry point queue fills and full rises.
`default_nettype none

module projected_joint_bounding_box (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [pjbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [pjbb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                  push,
  output logic                                 full,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_x,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_y,
  input  wire  signed [pjbb_pkg::POS_W-1:0]    pos_z,
  input  wire  [pjbb_pkg::MODE_W-1:0]          box_mode,
  input  wire                                  last_point,
  output logic                                 empty,
  input  wire                                  pop,
  output logic signed [pjbb_pkg::PIX_W-1:0]    min_col,
  output logic signed [pjbb_pkg::PIX_W-1:0]    min_row,
  output logic signed [pjbb_pkg::PIX_W-1:0]    max_col,
  output logic signed [pjbb_pkg::PIX_W-1:0]    max_row,
  output logic signed [pjbb_pkg::BLK_W-1:0]    min_block_col,
  output logic signed [pjbb_pkg::BLK_W-1:0]    min_block_row,
  output logic signed [pjbb_pkg::BLK_W-1:0]    max_block_col,
  output logic signed [pjbb_pkg::BLK_W-1:0]    max_block_row
);

  pjbb_pkg::mid_stat_t mid_stat;
  pjbb_pkg::point_t    mid_wr_data;
  pjbb_pkg::point_t    mid_rd_data;
  logic                mid_wr;
  logic                mid_rd;
  pjbb_pkg::result_t   res;

  // Projection front.
  pjbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .box_mode   (box_mode),
    .last_point (last_point),
    .mid_stat   (mid_stat),
    .mid_wr     (mid_wr),
    .mid_data   (mid_wr_data)
  );

  // Point queue between front and back.
  pjbb_mid_queue u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_wr_data),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_data),
    .stat    (mid_stat)
  );

  // Box back end with the result queue.
  pjbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_stat (mid_stat),
    .mid_data (mid_rd_data),
    .mid_rd   (mid_rd),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  // Result fields.
  assign min_col       = res.min_col;
  assign min_row       = res.min_row;
  assign max_col       = res.max_col;
  assign max_row       = res.max_row;
  assign min_block_col = res.min_block_col;
  assign min_block_row = res.min_block_row;
  assign max_block_col = res.max_block_col;
  assign max_block_row = res.max_block_row;

endmodule

`default_nettype wire
